// ----- rtl/hufd_pkg.sv -----
// Shared types and constants for the Huffman tree-walk decoder.
// Depends on nothing; imported by every module under rtl.
package hufd_pkg;

  localparam int unsigned NODE_COUNT    = 512;
  localparam int unsigned IDX_W         = 9;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned ADDR_W        = $clog2(NODE_COUNT);
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned TOP_BIT       = 7;
  localparam int unsigned CNT_W         = $clog2(BITS_PER_BYTE + 1);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef struct packed {
    logic cfg_wr;
    logic wr_node;
    logic load_byte;
    logic fetch_cur;
    logic step;
    logic take_leaf;
    logic fetch_root;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic leaf;
    logic bits_done;
    logic out_free;
    logic pend_valid;
  } status_t;

endpackage

// ----- rtl/hufd_datapath.sv -----
// Datapath of the Huffman decoder: node table memory, walk registers,
// pending symbol and output register. Depends on hufd_pkg.
module hufd_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hufd_pkg::cmd_t              cmd_i,
  output hufd_pkg::status_t           status_o,
  input  logic [hufd_pkg::IDX_W-1:0]  cfg_data_i,
  input  logic [hufd_pkg::IDX_W-1:0]  node_index_i,
  input  logic [hufd_pkg::IDX_W-1:0]  left_child_i,
  input  logic [hufd_pkg::IDX_W-1:0]  right_child_i,
  input  logic                        is_leaf_i,
  input  logic [hufd_pkg::SYM_W-1:0]  leaf_symbol_i,
  input  logic [hufd_pkg::SYM_W-1:0]  code_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hufd_pkg::SYM_W-1:0]  symbol_o,
  output logic                        last_o
);
  import hufd_pkg::*;

  node_t             node_mem [NODE_COUNT];
  node_t             rd_data_q;
  logic              rd_hit_q;
  node_t             rd_entry;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_hit;
  logic              wr_hit;

  logic [IDX_W-1:0]  root_q;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [SYM_W-1:0]  byte_q, byte_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_valid_q, pend_valid_d;
  logic [SYM_W-1:0]  pend_sym_q, pend_sym_d;
  logic              out_valid_q, out_valid_d;
  logic [SYM_W-1:0]  out_sym_q, out_sym_d;
  logic              out_last_q, out_last_d;
  logic [IDX_W-1:0]  child;

  assign rd_entry = rd_hit_q ? rd_data_q : node_t'('0);
  assign child    = byte_q[TOP_BIT] ? rd_entry.right : rd_entry.left;

  assign rd_en  = cmd_i.fetch_cur | cmd_i.step | cmd_i.fetch_root;
  always_comb begin
    if (cmd_i.step) begin
      rd_addr = child;
    end else if (cmd_i.fetch_root) begin
      rd_addr = root_q;
    end else begin
      rd_addr = cur_q;
    end
  end

  assign rd_hit = ({1'b0, rd_addr} < (IDX_W + 1)'(NODE_COUNT));
  assign wr_hit = ({1'b0, node_index_i} < (IDX_W + 1)'(NODE_COUNT));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_node && wr_hit) begin
      node_mem[node_index_i[ADDR_W-1:0]] <= '{left:  left_child_i,
                                             right: right_child_i,
                                             leaf:  is_leaf_i,
                                             sym:   leaf_symbol_i};
    end
    if (rd_en) begin
      rd_data_q <= node_mem[rd_addr[ADDR_W-1:0]];
      rd_hit_q  <= rd_hit;
    end
  end

  always_comb begin
    cur_d        = cur_q;
    byte_d       = byte_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    out_valid_d  = out_valid_q;
    out_sym_d    = out_sym_q;
    out_last_d   = out_last_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_byte) begin
      byte_d = code_byte_i;
      cnt_d  = '0;
    end
    if (cmd_i.step) begin
      cur_d  = child;
      byte_d = {byte_q[SYM_W-2:0], 1'b0};
      cnt_d  = cnt_q + CNT_W'(1);
    end
    if (cmd_i.take_leaf) begin
      cur_d        = root_q;
      pend_valid_d = 1'b1;
      pend_sym_d   = rd_entry.sym;
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_sym_d   = pend_sym_q;
        out_last_d  = 1'b0;
      end
    end
    if (cmd_i.flush) begin
      pend_valid_d = 1'b0;
      out_valid_d  = 1'b1;
      out_sym_d    = pend_sym_q;
      out_last_d   = 1'b1;
    end
    if (cmd_i.cfg_wr) begin
      cur_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q       <= '0;
      cur_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.cfg_wr) begin
        root_q <= cfg_data_i;
      end
      cur_q        <= cur_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    pend_sym_q <= pend_sym_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
  end

  assign status_o.leaf       = rd_entry.leaf;
  assign status_o.bits_done  = (cnt_q == CNT_W'(BITS_PER_BYTE));
  assign status_o.out_free   = ~out_valid_q | out_ready_i;
  assign status_o.pend_valid = pend_valid_q;

  assign out_valid_o = out_valid_q;
  assign symbol_o    = out_sym_q;
  assign last_o      = out_last_q;

endmodule

// ----- rtl/hufd_ctrl.sv -----
// Controller of the Huffman decoder: sequences root writes, node writes and the
// bit-by-bit tree walk. Depends on hufd_pkg.
module hufd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  output hufd_pkg::cmd_t      cmd_o,
  input  hufd_pkg::status_t   status_i
);
  import hufd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HERE  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       stall;

  assign stall = status_i.pend_valid & ~status_i.out_free;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o   = 1'b1;
        in_ready_o    = ~cfg_valid_i;
        cmd_o.cfg_wr  = cfg_valid_i;
        if (in_valid_i && !cfg_valid_i) begin
          if (command_i == CMD_WRITE) begin
            cmd_o.wr_node = 1'b1;
          end else begin
            cmd_o.load_byte = 1'b1;
            cmd_o.fetch_cur = 1'b1;
            state_d         = ST_HERE;
          end
        end
      end
      ST_HERE: begin
        cmd_o.step = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.leaf) begin
          if (!stall) begin
            cmd_o.take_leaf = 1'b1;
            if (status_i.bits_done) begin
              state_d = ST_FLUSH;
            end else begin
              cmd_o.fetch_root = 1'b1;
              state_d          = ST_HERE;
            end
          end
        end else if (status_i.bits_done) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!status_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_ninth_bit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !status_i.bits_done)
    else $error("bit consumed after the byte was exhausted");

  a_cmd_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.wr_node, cmd_o.fetch_cur, cmd_o.step, cmd_o.take_leaf, cmd_o.flush}))
    else $error("conflicting datapath commands");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take_leaf && status_i.pend_valid) || cmd_o.flush |-> status_i.out_free)
    else $error("output register overwritten while held");

  a_flush_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH && state_d == ST_IDLE |=> !status_i.pend_valid)
    else $error("pending symbol left behind at end of byte");

endmodule

// ----- rtl/huffman_tree_walk_decoder.sv -----
// Huffman tree-walk decoder top level: controller plus datapath.
// Depends on hufd_pkg, hufd_ctrl and hufd_datapath.
// A decode transaction makes one node table read per bit plus one root read after each
// symbol found before the eighth bit, and takes longer while the output register is
// held. Reset clears root and current node to 0; node table contents stay undefined
// until written.
module huffman_tree_walk_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hufd_pkg::IDX_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [hufd_pkg::IDX_W-1:0]  node_index_i,
  input  logic [hufd_pkg::IDX_W-1:0]  left_child_i,
  input  logic [hufd_pkg::IDX_W-1:0]  right_child_i,
  input  logic                        is_leaf_i,
  input  logic [hufd_pkg::SYM_W-1:0]  leaf_symbol_i,
  input  logic [hufd_pkg::SYM_W-1:0]  code_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hufd_pkg::SYM_W-1:0]  symbol_o,
  output logic                        last_o
);
  import hufd_pkg::*;

  cmd_t    cmd;
  status_t status;

  hufd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  hufd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_data_i    (cfg_data_i),
    .node_index_i  (node_index_i),
    .left_child_i  (left_child_i),
    .right_child_i (right_child_i),
    .is_leaf_i     (is_leaf_i),
    .leaf_symbol_i (leaf_symbol_i),
    .code_byte_i   (code_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_o      (symbol_o),
    .last_o        (last_o)
  );

endmodule
